### hdl/rwr_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions of the reorder window receiver
// no dependencies

package rwr_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int MAX_SEQ_BITS = 16;
    localparam int SEQ_W        = 16;
    localparam int IDX_W        = $clog2(MAX_WINDOW);

    localparam logic [1:0] REG_SEQ_BITS    = 2'd0;
    localparam logic [1:0] REG_WINDOW_SIZE = 2'd1;
    localparam logic [1:0] REG_INITIAL_SEQ = 2'd2;

    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_BUFFER  = 2'd1,
        KIND_DUP     = 2'd2,
        KIND_OUTSIDE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic load;
        logic eval;
        logic drain;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic chain;
    } t_stat;

    function automatic logic [SEQ_W-1:0] seq_mask(input logic [4:0] bits);
        logic [4:0]     b;
        logic [SEQ_W:0] p;
        b = bits;
        if (b == 5'd0) b = 5'd1;
        if (b > 5'(MAX_SEQ_BITS)) b = 5'(MAX_SEQ_BITS);
        p = (SEQ_W+1)'(1) << b;
        return SEQ_W'(p - (SEQ_W+1)'(1));
    endfunction

    function automatic logic [SEQ_W-1:0] win_len(input logic [6:0] size,
                                                 input logic [SEQ_W-1:0] mask);
        logic [SEQ_W-1:0] w;
        w = SEQ_W'(size);
        if (w == '0) w = SEQ_W'(1);
        if (w > SEQ_W'(MAX_WINDOW)) w = SEQ_W'(MAX_WINDOW);
        if (w > mask) w = mask;
        if (w == '0) w = SEQ_W'(1);
        return w;
    endfunction

endpackage

### hdl/rwr_ctrl.sv
`timescale 1ns / 1ps
// control state machine of the reorder window receiver
// depends on rwr_pkg; steers rwr_dp through t_cmd and reads t_stat

module rwr_ctrl import rwr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_stat.hit && i_stat.chain) n_state = ST_DRAIN;
                else n_state = ST_IDLE;
            end
            ST_DRAIN: begin
                if (!i_stat.chain) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            ST_DRAIN: begin
                o_cmd.drain = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

### hdl/rwr_dp.sv
`timescale 1ns / 1ps
// datapath of the reorder window receiver: config registers, expected number,
// held bitmap and registered result; depends on rwr_pkg

module rwr_dp import rwr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic [SEQ_W-1:0] i_seq,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    output logic             o_valid,
    output logic [1:0]       o_kind,
    output logic [SEQ_W-1:0] o_seq_out,
    output logic             o_last,
    output logic [SEQ_W-1:0] o_expected_now
);

    logic [4:0]            r_seq_bits,  n_seq_bits;
    logic [6:0]            r_win_size,  n_win_size;
    logic [SEQ_W-1:0]      r_init_seq,  n_init_seq;
    logic [SEQ_W-1:0]      r_expected,  n_expected;
    logic [MAX_WINDOW-1:0] r_held,      n_held;
    logic [SEQ_W-1:0]      r_seq,       n_seq;
    logic                  r_valid,     n_valid;
    t_kind                 r_kind,      n_kind;
    logic [SEQ_W-1:0]      r_seq_out,   n_seq_out;
    logic                  r_last,      n_last;
    logic [SEQ_W-1:0]      r_exp_now,   n_exp_now;

    logic [SEQ_W-1:0] mask;
    logic [SEQ_W-1:0] win;
    logic [SEQ_W-1:0] diff;
    logic [SEQ_W-1:0] exp_inc;
    logic [IDX_W-1:0] idx;
    logic             out_range;
    logic             hit;
    logic             in_win;

    assign mask      = seq_mask(r_seq_bits);
    assign win       = win_len(r_win_size, mask);
    assign out_range = (r_seq & ~mask) != '0;
    assign diff      = (r_seq - r_expected) & mask;
    assign idx       = diff[IDX_W-1:0];
    assign hit       = !out_range && (diff == '0);
    assign in_win    = !out_range && (diff < win);
    assign exp_inc   = (r_expected + SEQ_W'(1)) & mask;

    assign o_stat.hit   = hit;
    assign o_stat.chain = r_held[1];

    always_comb begin
        n_seq_bits = r_seq_bits;
        n_win_size = r_win_size;
        n_init_seq = r_init_seq;
        n_expected = r_expected;
        n_held     = r_held;
        n_seq      = r_seq;
        n_valid    = 1'b0;
        n_kind     = r_kind;
        n_seq_out  = r_seq_out;
        n_last     = r_last;
        n_exp_now  = r_exp_now;

        if (i_cfg_valid && (i_cfg_index == REG_SEQ_BITS || i_cfg_index == REG_WINDOW_SIZE
                            || i_cfg_index == REG_INITIAL_SEQ)) begin
            case (i_cfg_index)
                REG_SEQ_BITS:    n_seq_bits = i_cfg_data[4:0];
                REG_WINDOW_SIZE: n_win_size = i_cfg_data[6:0];
                REG_INITIAL_SEQ: n_init_seq = i_cfg_data;
                default:         n_seq_bits = r_seq_bits;
            endcase
            // any write to one of the three registers restarts the window
            n_expected = n_init_seq & seq_mask(n_seq_bits);
            n_held     = '0;
        end else if (i_cmd.load) begin
            n_seq = i_seq;
        end else if (i_cmd.drain || (i_cmd.eval && hit)) begin
            n_valid    = 1'b1;
            n_kind     = KIND_DELIVER;
            n_seq_out  = r_expected;
            n_last     = !r_held[1];
            n_exp_now  = exp_inc;
            n_expected = exp_inc;
            n_held     = r_held >> 1;
        end else if (i_cmd.eval) begin
            n_valid   = 1'b1;
            n_seq_out = r_seq;
            n_last    = 1'b1;
            n_exp_now = r_expected;
            if (in_win) begin
                if (r_held[idx]) begin
                    n_kind = KIND_DUP;
                end else begin
                    n_kind      = KIND_BUFFER;
                    n_held[idx] = 1'b1;
                end
            end else begin
                n_kind = KIND_OUTSIDE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_bits <= 5'd8;
            r_win_size <= 7'd4;
            r_init_seq <= '0;
            r_expected <= '0;
            r_held     <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_seq_bits <= n_seq_bits;
            r_win_size <= n_win_size;
            r_init_seq <= n_init_seq;
            r_expected <= n_expected;
            r_held     <= n_held;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq     <= n_seq;
        r_kind    <= n_kind;
        r_seq_out <= n_seq_out;
        r_last    <= n_last;
        r_exp_now <= n_exp_now;
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_seq_out      = r_seq_out;
    assign o_last         = r_last;
    assign o_expected_now = r_exp_now;

endmodule

### hdl/reorder_window_receiver_core.sv
`timescale 1ns / 1ps
// top level of the reorder window receiver
// depends on rwr_pkg, rwr_ctrl and rwr_dp
// usage:
//   a packet number beat is taken on i_seq when i_start is high and o_busy low.
//   results leave on o_kind, o_seq_out, o_last and o_expected_now, each for one
//   cycle marked by o_valid; the receiver must take every result as it comes.
//   o_last flags the final result of a packet.
//   a packet that is buffered or dropped gives one result, evaluated in ST_EVAL
//   from the registered packet number and registered again for output; o_busy
//   is low again in that result's cycle, so the next packet can then be taken.
//   a packet that is delivered gives one result per cycle, the first as for a
//   dropped packet, one more per consecutive buffered packet (up to 64 in all);
//   the next packet can be taken in the cycle of the last result. the results
//   come from the one-shift-per-cycle drain of the held bitmap in ST_DRAIN.
//   config writes on i_cfg_* are always ready; each valid write to index 0, 1
//   or 2 restarts the window (expected number from initial_seq, bitmap
//   cleared). write only while o_busy is low and no results are pending.
//   synchronous reset restores seq_bits 8, window_size 4, initial_seq 0 and an
//   empty window.

module reorder_window_receiver_core import rwr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [SEQ_W-1:0] i_seq,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    output logic             o_valid,
    output logic [1:0]       o_kind,
    output logic [SEQ_W-1:0] o_seq_out,
    output logic             o_last,
    output logic [SEQ_W-1:0] o_expected_now
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    rwr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    rwr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_seq          (i_seq),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_seq_out      (o_seq_out),
        .o_last         (o_last),
        .o_expected_now (o_expected_now)
    );

endmodule
